[hdl/skt_pkg.sv]
package skt_pkg;

	localparam int CAPACITY_DEF  = 64;
	localparam int KEY_WIDTH_DEF = 32;

	localparam int KEY_IN_W    = 32;
	localparam int STATUS_W    = 3;
	localparam int POS_W       = 6;
	localparam int COUNT_OUT_W = 7;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_FULL      = 3'd1,
		ST_DUPLICATE = 3'd2,
		ST_FOUND     = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_PROBE,
		CS_COMPARE,
		CS_SHIFT,
		CS_DRAIN,
		CS_FILL
	} ctl_state_t;

	typedef struct packed {
		logic    load;
		logic    probe_rd;
		logic    step;
		logic    shift_init;
		logic    shift_rd;
		logic    fill;
		logic    emit;
		status_t emit_code;
	} ctl_cmd_t;

	typedef struct packed {
		logic is_search;
		logic full;
		logic range_empty;
		logic key_match;
		logic shift_more;
	} dp_stat_t;

endpackage

[hdl/skt_ctrl.sv]
module skt_ctrl
	import skt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd,
	output logic     busy
);

	ctl_state_t state_q;
	ctl_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			CS_IDLE: begin
				if (start) begin
					state_nxt = CS_PROBE;
				end
			end
			CS_PROBE: begin
				if (!stat.is_search && stat.full) begin
					state_nxt = CS_IDLE;
				end else if (stat.range_empty) begin
					state_nxt = stat.is_search ? CS_IDLE : CS_SHIFT;
				end else begin
					state_nxt = CS_COMPARE;
				end
			end
			CS_COMPARE: begin
				state_nxt = stat.key_match ? CS_IDLE : CS_PROBE;
			end
			CS_SHIFT: begin
				if (!stat.shift_more) begin
					state_nxt = CS_DRAIN;
				end
			end
			CS_DRAIN: begin
				state_nxt = CS_FILL;
			end
			CS_FILL: begin
				state_nxt = CS_IDLE;
			end
			default: begin
				state_nxt = CS_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.emit_code = ST_INSERTED;
		case (state_q)
			CS_IDLE: begin
				cmd.load = start;
			end
			CS_PROBE: begin
				if (!stat.is_search && stat.full) begin
					cmd.emit      = 1'b1;
					cmd.emit_code = ST_FULL;
				end else if (stat.range_empty) begin
					if (stat.is_search) begin
						cmd.emit      = 1'b1;
						cmd.emit_code = ST_NOT_FOUND;
					end else begin
						cmd.shift_init = 1'b1;
					end
				end else begin
					cmd.probe_rd = 1'b1;
				end
			end
			CS_COMPARE: begin
				if (stat.key_match) begin
					cmd.emit      = 1'b1;
					cmd.emit_code = stat.is_search ? ST_FOUND : ST_DUPLICATE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			CS_SHIFT: begin
				cmd.shift_rd = stat.shift_more;
			end
			CS_DRAIN: begin
			end
			CS_FILL: begin
				cmd.fill      = 1'b1;
				cmd.emit      = 1'b1;
				cmd.emit_code = ST_INSERTED;
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != CS_IDLE);

endmodule

[hdl/skt_datapath.sv]
module skt_datapath
	import skt_pkg::*;
#(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   command,
	input  logic [KEY_IN_W-1:0]    key,
	input  ctl_cmd_t               cmd,
	output dp_stat_t               stat,
	output logic                   done,
	output logic [STATUS_W-1:0]    status,
	output logic [POS_W-1:0]       position,
	output logic [COUNT_OUT_W-1:0] stored_count
);

	localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int KX_W   = KEY_WIDTH + KEY_IN_W;
	localparam int PX_W   = IDX_W + POS_W;
	localparam int CX_W   = CNT_W + COUNT_OUT_W;

	logic [KEY_WIDTH-1:0] mem_q [CAPACITY];
	logic [KEY_WIDTH-1:0] rd_data_q;

	logic [CNT_W-1:0]     count_q;
	logic                 cmd_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [CNT_W-1:0]     lo_q;
	logic [CNT_W-1:0]     hi_q;
	logic [IDX_W-1:0]     mid_q;
	logic [CNT_W-1:0]     idx_q;
	logic                 wr_pend_s1;
	logic [IDX_W-1:0]     wr_addr_s1;

	logic                 done_q;
	logic [STATUS_W-1:0]  status_q;
	logic [POS_W-1:0]     position_q;
	logic [COUNT_OUT_W-1:0] stored_count_q;

	logic [KX_W-1:0]      key_ext;
	logic [CNT_W-1:0]     mid_w;
	logic [CNT_W-1:0]     idx_m1;
	logic [CNT_W-1:0]     count_nxt;
	logic                 rd_en;
	logic [IDX_W-1:0]     rd_addr;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;
	logic [KEY_WIDTH-1:0] wr_data;
	logic [IDX_W-1:0]     pos_idx;
	logic [PX_W-1:0]      pos_ext;
	logic [CX_W-1:0]      cnt_ext;

	assign key_ext   = KX_W'(key);
	assign mid_w     = lo_q + ((hi_q - lo_q) >> 1);
	assign idx_m1    = idx_q - CNT_W'(1);
	assign count_nxt = cmd.fill ? count_q + CNT_W'(1) : count_q;

	assign rd_en   = cmd.probe_rd || cmd.shift_rd;
	assign rd_addr = cmd.shift_rd ? idx_m1[IDX_W-1:0] : mid_w[IDX_W-1:0];
	assign wr_en   = wr_pend_s1 || cmd.fill;
	assign wr_addr = wr_pend_s1 ? wr_addr_s1 : lo_q[IDX_W-1:0];
	assign wr_data = wr_pend_s1 ? rd_data_q : key_q;

	// key store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			wr_pend_s1 <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			count_q    <= count_nxt;
			wr_pend_s1 <= cmd.shift_rd;
			done_q     <= cmd.emit;
		end
	end

	always_comb begin
		case (cmd.emit_code)
			ST_FOUND:    pos_idx = mid_q;
			ST_INSERTED: pos_idx = lo_q[IDX_W-1:0];
			default:     pos_idx = '0;
		endcase
	end

	assign pos_ext = PX_W'(pos_idx);
	assign cnt_ext = CX_W'(count_nxt);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= command;
			key_q <= key_ext[KEY_WIDTH-1:0];
			lo_q  <= '0;
			hi_q  <= count_q;
		end
		if (cmd.probe_rd) begin
			mid_q <= mid_w[IDX_W-1:0];
		end
		if (cmd.step) begin
			if (key_q < rd_data_q) begin
				hi_q <= CNT_W'(mid_q);
			end else begin
				lo_q <= CNT_W'(mid_q) + CNT_W'(1);
			end
		end
		if (cmd.shift_init) begin
			idx_q <= count_q;
		end
		if (cmd.shift_rd) begin
			idx_q      <= idx_m1;
			wr_addr_s1 <= idx_q[IDX_W-1:0];
		end
		if (cmd.emit) begin
			status_q       <= cmd.emit_code;
			position_q     <= pos_ext[POS_W-1:0];
			stored_count_q <= cnt_ext[COUNT_OUT_W-1:0];
		end
	end

	assign stat.is_search   = (cmd_q == CMD_SEARCH);
	assign stat.full        = (count_q == CNT_W'(CAPACITY));
	assign stat.range_empty = (lo_q >= hi_q);
	assign stat.key_match   = (key_q == rd_data_q);
	assign stat.shift_more  = (idx_q > lo_q);

	assign done         = done_q;
	assign status       = status_q;
	assign position     = position_q;
	assign stored_count = stored_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_single_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill |-> !wr_pend_s1)
		else $error("key fill collides with shift write");

	a_fill_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not advance entry count");

	a_shift_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift_rd |-> (idx_q <= count_q) && (idx_q > lo_q))
		else $error("shift index outside table");

endmodule

[hdl/sorted_key_table_top.sv]
// search: each probe reads the middle entry (probe state), then compares it (compare state);
// done follows a match (found) or an empty range (not found), after at most log2(n)+1 probes
// insert: as a search; a match gives duplicate, else entries move up one by one, then fill
// full table: an insert is answered full from the probe state, with no search
// one item at a time: busy is high from acceptance until the cycle done is shown
// reset clears the entry count and control; key store contents stay unknown until written
module sorted_key_table_top
	import skt_pkg::*;
#(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   command,
	input  logic [KEY_IN_W-1:0]    key,
	output logic                   done,
	output logic [STATUS_W-1:0]    status,
	output logic [POS_W-1:0]       position,
	output logic [COUNT_OUT_W-1:0] stored_count
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	skt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	skt_datapath #(
		.CAPACITY  (CAPACITY),
		.KEY_WIDTH (KEY_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.command      (command),
		.key          (key),
		.cmd          (cmd),
		.stat         (stat),
		.done         (done),
		.status       (status),
		.position     (position),
		.stored_count (stored_count)
	);

endmodule
